// ===== rtl/core/ppdt_pkg.sv =====
// Shared types, sizes and codes for the palette pixel dedup table.
package ppdt_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int LEVEL_W       = 8;
  localparam int PIXEL_W       = 32;
  localparam int NUM_PRIM      = 3;

  localparam logic [1:0] REG_RED_MASK   = 2'd0;
  localparam logic [1:0] REG_GREEN_MASK = 2'd1;
  localparam logic [1:0] REG_BLUE_MASK  = 2'd2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_MERGED    = 3'd1,
    STAT_DROPPED   = 3'd2,
    STAT_READ_OOR  = 3'd3,
    STAT_READ_OK   = 3'd4
  } ppdt_status_t;

  typedef enum logic [1:0] {
    RES_ADDED   = 2'd0,
    RES_MERGED  = 2'd1,
    RES_DROPPED = 2'd2,
    RES_READ    = 2'd3
  } ppdt_res_kind_t;

  typedef enum logic [1:0] {
    RUN_SEEK = 2'd0,
    RUN_IN   = 2'd1,
    RUN_DONE = 2'd2
  } ppdt_run_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PACK    = 3'd1,
    ST_PIXEL   = 3'd2,
    ST_SCAN    = 3'd3,
    ST_WRITE   = 3'd4,
    ST_RD_ADDR = 3'd5,
    ST_RD_DATA = 3'd6,
    ST_DONE    = 3'd7
  } ppdt_state_t;

  typedef struct packed {
    logic           item_load;
    logic           pack_clr;
    logic           pack_en;
    logic           pixel_load;
    logic           scan_clr;
    logic           scan_en;
    logic           rd_item;
    logic           write_en;
    logic           res_load;
    ppdt_res_kind_t res_kind;
    logic           out_load;
  } ppdt_cmd_t;

  typedef struct packed {
    logic pack_done;
    logic hit;
    logic miss;
    logic full;
    logic out_free;
  } ppdt_stat_t;

endpackage

// ===== rtl/core/ppdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ppdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ppdt_ctrl.sv =====
// Sequencer for add and read items of the palette table.
module ppdt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_opcode,
  output logic                in_ready,
  input  ppdt_pkg::ppdt_stat_t stat,
  output ppdt_pkg::ppdt_cmd_t  cmd
);

  import ppdt_pkg::*;

  ppdt_state_t state_r;
  ppdt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          cmd.pack_clr  = 1'b1;
          cmd.scan_clr  = 1'b1;
          state_nxt     = (in_opcode == OP_READ) ? ST_RD_ADDR : ST_PACK;
        end
      end
      ST_PACK: begin
        if (stat.pack_done) begin
          state_nxt = ST_PIXEL;
        end else begin
          cmd.pack_en = 1'b1;
        end
      end
      ST_PIXEL: begin
        cmd.pixel_load = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_MERGED;
          state_nxt    = ST_DONE;
        end else if (stat.miss) begin
          if (stat.full) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_DROPPED;
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_WRITE;
          end
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.write_en = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_ADDED;
        state_nxt    = ST_DONE;
      end
      ST_RD_ADDR: begin
        cmd.rd_item = 1'b1;
        state_nxt   = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_READ;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ppdt_dp.sv =====
// Datapath: mask registers, pixel packing, palette stores, search and result registers.
module ppdt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppdt_pkg::ppdt_cmd_t  cmd,
  output ppdt_pkg::ppdt_stat_t stat,
  // item fields
  input  logic [7:0]           red_level,
  input  logic [7:0]           green_level,
  input  logic [7:0]           blue_level,
  input  logic [7:0]           entry_index,
  input  logic [1:0]           primary_select,
  // register port
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_sel,
  input  logic [31:0]          cfg_wdata,
  output logic [31:0]          cfg_rdata,
  // result
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [31:0]          out_pixel_value,
  output logic [7:0]           out_result_index,
  output logic [2:0]           out_status,
  output logic [7:0]           out_selected_level,
  output logic [8:0]           out_entry_count
);

  import ppdt_pkg::*;

  // configuration
  logic [PIXEL_W-1:0] mask_r [NUM_PRIM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[0] <= 32'h00FF_0000;
      mask_r[1] <= 32'h0000_FF00;
      mask_r[2] <= 32'h0000_00FF;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_RED_MASK:   mask_r[0] <= cfg_wdata;
        REG_GREEN_MASK: mask_r[1] <= cfg_wdata;
        REG_BLUE_MASK:  mask_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_RED_MASK:   cfg_rdata = mask_r[0];
      REG_GREEN_MASK: cfg_rdata = mask_r[1];
      REG_BLUE_MASK:  cfg_rdata = mask_r[2];
      default:        cfg_rdata = '0;
    endcase
  end

  // item hold
  logic [LEVEL_W-1:0] lvl_r [NUM_PRIM];
  logic [7:0]         idx_r;
  logic [1:0]         sel_r;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      lvl_r[0] <= red_level;
      lvl_r[1] <= green_level;
      lvl_r[2] <= blue_level;
      idx_r    <= entry_index;
      sel_r    <= primary_select;
    end
  end

  // mask run search, one bit position per cycle
  logic [5:0] bitpos_r;
  ppdt_run_t  run_r   [NUM_PRIM];
  logic [4:0] shift_r [NUM_PRIM];
  logic [3:0] width_r [NUM_PRIM];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.pack_clr) begin
      bitpos_r <= '0;
      for (int k = 0; k < NUM_PRIM; k++) begin
        run_r[k]   <= RUN_SEEK;
        shift_r[k] <= '0;
        width_r[k] <= '0;
      end
    end else if (cmd.pack_en) begin
      bitpos_r <= bitpos_r + 6'd1;
      for (int k = 0; k < NUM_PRIM; k++) begin
        case (run_r[k])
          RUN_SEEK: begin
            if (mask_r[k][bitpos_r[4:0]]) begin
              run_r[k]   <= RUN_IN;
              shift_r[k] <= bitpos_r[4:0];
              width_r[k] <= 4'd1;
            end
          end
          RUN_IN: begin
            if (!mask_r[k][bitpos_r[4:0]]) begin
              run_r[k] <= RUN_DONE;
            end else if (width_r[k] < 4'd8) begin
              width_r[k] <= width_r[k] + 4'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign stat.pack_done = bitpos_r[5];

  // place each level: cut to run width, move to run base, clip to mask
  logic [PIXEL_W-1:0] part   [NUM_PRIM];
  logic [LEVEL_W-1:0] cut    [NUM_PRIM];
  logic [PIXEL_W-1:0] pixel_comb;

  always_comb begin
    pixel_comb = '0;
    for (int k = 0; k < NUM_PRIM; k++) begin
      cut[k]     = lvl_r[k] >> (4'd8 - width_r[k]);
      part[k]    = (PIXEL_W'(cut[k]) << shift_r[k]) & mask_r[k];
      pixel_comb = pixel_comb | part[k];
    end
  end

  logic [PIXEL_W-1:0] pixel_r;

  always_ff @(posedge clk) begin
    if (cmd.pixel_load) begin
      pixel_r <= pixel_comb;
    end
  end

  // palette stores
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        scan_idx_r;
  logic                    pend_v_r;
  logic [CNT_W-1:0]        pend_idx_r;
  logic                    scan_issue;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [PIXEL_W-1:0]      pix_rdata;
  logic [3*LEVEL_W-1:0]    lvl_rdata;

  assign scan_issue = cmd.scan_en && (scan_idx_r < count_r);
  assign ram_re     = scan_issue || cmd.rd_item;
  assign ram_raddr  = cmd.rd_item ? ADDR_W'(idx_r) : scan_idx_r[ADDR_W-1:0];

  ppdt_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (cmd.write_en),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (pixel_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (pix_rdata)
  );

  ppdt_ram #(
    .WIDTH (3 * LEVEL_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_level_ram (
    .clk   (clk),
    .we    (cmd.write_en),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata ({lvl_r[0], lvl_r[1], lvl_r[2]}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (lvl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.write_en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // search: one entry issued per cycle, compared in the cycle after it is issued
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_clr) begin
      scan_idx_r <= '0;
      pend_v_r   <= 1'b0;
    end else if (cmd.scan_en) begin
      pend_v_r <= scan_issue;
      if (scan_issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
        pend_idx_r <= scan_idx_r;
      end
    end
  end

  assign stat.hit  = pend_v_r && (pix_rdata == pixel_r);
  assign stat.miss = !pend_v_r && (scan_idx_r >= count_r);
  assign stat.full = (count_r == CNT_W'(PALETTE_DEPTH));

  // result registers
  logic [PIXEL_W-1:0] res_pixel_r;
  logic [7:0]         res_index_r;
  ppdt_status_t       res_status_r;
  logic [7:0]         res_level_r;
  logic [8:0]         res_count_r;
  logic               in_range;
  logic [7:0]         sel_level;

  assign in_range = (32'(idx_r) < 32'(count_r));

  always_comb begin
    case (sel_r)
      SEL_RED:   sel_level = lvl_rdata[23:16];
      SEL_GREEN: sel_level = lvl_rdata[15:8];
      SEL_BLUE:  sel_level = lvl_rdata[7:0];
      default:   sel_level = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RES_ADDED: begin
          res_pixel_r  <= pixel_r;
          res_index_r  <= 8'(count_r);
          res_status_r <= STAT_ADDED;
          res_level_r  <= '0;
          res_count_r  <= 9'(count_r + CNT_W'(1));
        end
        RES_MERGED: begin
          res_pixel_r  <= pixel_r;
          res_index_r  <= 8'(pend_idx_r);
          res_status_r <= STAT_MERGED;
          res_level_r  <= '0;
          res_count_r  <= 9'(count_r);
        end
        RES_DROPPED: begin
          res_pixel_r  <= pixel_r;
          res_index_r  <= '0;
          res_status_r <= STAT_DROPPED;
          res_level_r  <= '0;
          res_count_r  <= 9'(count_r);
        end
        RES_READ: begin
          res_index_r <= idx_r;
          res_count_r <= 9'(count_r);
          if (in_range) begin
            res_pixel_r  <= pix_rdata;
            res_level_r  <= sel_level;
            res_status_r <= STAT_READ_OK;
          end else begin
            res_pixel_r  <= '0;
            res_level_r  <= '0;
            res_status_r <= STAT_READ_OOR;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel_value    <= res_pixel_r;
      out_result_index   <= res_index_r;
      out_status         <= res_status_r;
      out_selected_level <= res_level_r;
      out_entry_count    <= res_count_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// ===== rtl/core/palette_pixel_dedup_table_unit.sv =====
// Top level of the palette pixel dedup table: stream ports, register port, controller and datapath.
// One item at a time. A read addresses both palette RAMs, then registers the result and hands it
// to the output register. An add searches the masks for their runs bit by bit, then compares one
// stored pixel per cycle through the pixel RAM read port, then loads, writes and hands off; a
// new color at a full table is dropped instead of written.
// A finished result waits in the output register, so the next item is taken while it is unread.
// Reset (rst_n low at a clock edge) clears the entry count and the control state and restores
// the masks to 0x00FF0000, 0x0000FF00, 0x000000FF; the palette RAMs are not cleared.
module palette_pixel_dedup_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // red_level, green_level, blue_level, entry_index,
                                  // primary_select (low bit up), zero fill
  input  logic [0:0]  in_tuser,   // opcode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // pixel_value, result_index, selected_level,
                                  // entry_count (low bit up), zero fill
  output logic [2:0]  out_tuser,  // status
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import ppdt_pkg::*;

  ppdt_cmd_t  cmd;
  ppdt_stat_t stat;
  logic       cfg_we;

  logic [31:0] pixel_value;
  logic [7:0]  result_index;
  logic [2:0]  status;
  logic [7:0]  selected_level;
  logic [8:0]  entry_count;

  // register write lands on the access cycle; pready never stalls
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  ppdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser[0]),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ppdt_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .red_level          (in_tdata[7:0]),
    .green_level        (in_tdata[15:8]),
    .blue_level         (in_tdata[23:16]),
    .entry_index        (in_tdata[31:24]),
    .primary_select     (in_tdata[33:32]),
    .cfg_we             (cfg_we),
    .cfg_sel            (cfg_paddr[3:2]),
    .cfg_wdata          (cfg_pwdata),
    .cfg_rdata          (cfg_prdata),
    .out_ready          (out_tready),
    .out_valid          (out_tvalid),
    .out_pixel_value    (pixel_value),
    .out_result_index   (result_index),
    .out_status         (status),
    .out_selected_level (selected_level),
    .out_entry_count    (entry_count)
  );

  // pack the result beat
  assign out_tdata = {7'd0, entry_count, selected_level, result_index, pixel_value};
  assign out_tuser = status;

endmodule

// ===== bench/palette_pixel_dedup_table_unit_test.sv =====
// Self-checking bench for the palette pixel dedup table: directed table, random phases, predictor.
module palette_pixel_dedup_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppdt_pkg::*;

  // Read selector with no primary behind it; the package names only the three real ones.
  localparam logic [1:0] SEL_NONE = 2'd3;

  // Idle tail after the last beat, longer than the longest add.
  localparam int TAIL_CYCLES = 300;
  localparam int PHASE_ITEMS = 166;
  localparam int NUM_PHASES  = 8;

  typedef struct {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] idx;
    logic [1:0] sel;
  } palette_item_t;

  typedef struct {
    logic [31:0]  pixel;
    logic [7:0]   index;
    ppdt_status_t status;
    logic [7:0]   level;
    logic [8:0]   count;
  } palette_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    palette_item_t   item;
    bit              typed;
    palette_result_t want;
    logic [1:0]      reg_id;
    logic [31:0]     reg_value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor copy of the palette and the masks.
  logic [31:0] pred_pixels [PALETTE_DEPTH];
  logic [23:0] pred_levels [PALETTE_DEPTH];
  logic [8:0]  pred_count;
  logic [31:0] pred_mask [3];

  palette_result_t awaited_results [$];
  int              mismatch_count = 0;
  bit              steady = 1'b0;   // suppress idling on both sides while set

  palette_pixel_dedup_table_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // Place one level under its mask: cut to the lowest run (at most 8 bits wide),
  // shift to the run's lowest bit, then trim with the whole mask.
  function automatic logic [31:0] place_level(input logic [7:0] level, input logic [31:0] mask);
    int          shift;
    int          width;
    logic [63:0] part;
    shift = 0;
    width = 0;
    if (mask == 32'd0) return 32'd0;
    while (!mask[shift]) shift++;
    while (shift + width < 32 && mask[shift + width]) width++;
    if (width > 8) width = 8;
    part = {56'd0, level >> (8 - width)} << shift;
    return part[31:0] & mask;
  endfunction

  // Pack, search and append exactly as the block does; updates the predictor's palette.
  function automatic palette_result_t palette_result_of(input palette_item_t item);
    palette_result_t res;
    logic [31:0]     pixel;
    int              hit;
    res.pixel  = 32'd0;
    res.index  = 8'd0;
    res.level  = 8'd0;
    res.status = STAT_ADDED;
    if (item.op == OP_ADD) begin
      pixel = place_level(item.red, pred_mask[REG_RED_MASK]) |
              place_level(item.green, pred_mask[REG_GREEN_MASK]) |
              place_level(item.blue, pred_mask[REG_BLUE_MASK]);
      res.pixel = pixel;
      hit = -1;
      for (int i = 0; i < pred_count; i++) begin
        if (hit < 0 && pred_pixels[i] == pixel) hit = i;
      end
      if (hit >= 0) begin
        res.index  = hit[7:0];
        res.status = STAT_MERGED;
      end else if (pred_count < PALETTE_DEPTH) begin
        pred_pixels[pred_count] = pixel;
        pred_levels[pred_count] = {item.red, item.green, item.blue};
        res.index  = pred_count[7:0];
        res.status = STAT_ADDED;
        pred_count++;
      end else begin
        // full table, new color: report the pixel, keep the table
        res.status = STAT_DROPPED;
      end
    end else begin
      res.index = item.idx;
      if (item.idx < pred_count) begin
        res.pixel  = pred_pixels[item.idx];
        res.status = STAT_READ_OK;
        case (item.sel)
          SEL_RED:   res.level = pred_levels[item.idx][23:16];
          SEL_GREEN: res.level = pred_levels[item.idx][15:8];
          SEL_BLUE:  res.level = pred_levels[item.idx][7:0];
          default:   res.level = 8'd0;
        endcase
      end else begin
        res.status = STAT_READ_OOR;
      end
    end
    res.count = pred_count;
    return res;
  endfunction

  function automatic stim_row_t item_row(input logic op, input logic [7:0] red,
                                         input logic [7:0] green, input logic [7:0] blue,
                                         input logic [7:0] idx, input logic [1:0] sel);
    stim_row_t row;
    row.kind       = ROW_ITEM;
    row.item.op    = op;
    row.item.red   = red;
    row.item.green = green;
    row.item.blue  = blue;
    row.item.idx   = idx;
    row.item.sel   = sel;
    row.typed      = 1'b0;
    row.reg_id     = REG_RED_MASK;
    row.reg_value  = 32'd0;
    return row;
  endfunction

  // Row whose result is written out by hand instead of taken from the predictor.
  function automatic stim_row_t checked_row(input logic op, input logic [7:0] red,
                                            input logic [7:0] green, input logic [7:0] blue,
                                            input logic [7:0] idx, input logic [1:0] sel,
                                            input logic [31:0] pixel, input logic [7:0] index,
                                            input ppdt_status_t status, input logic [7:0] level,
                                            input logic [8:0] count);
    stim_row_t row;
    row = item_row(op, red, green, blue, idx, sel);
    row.typed       = 1'b1;
    row.want.pixel  = pixel;
    row.want.index  = index;
    row.want.status = status;
    row.want.level  = level;
    row.want.count  = count;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] reg_id, input logic [31:0] value);
    stim_row_t row;
    row = item_row(OP_ADD, 8'd0, 8'd0, 8'd0, 8'd0, SEL_RED);
    row.kind      = ROW_CFG;
    row.reg_id    = reg_id;
    row.reg_value = value;
    return row;
  endfunction

  function automatic logic [31:0] random_run_mask();
    logic [63:0] run;
    run = ((64'd1 << $urandom_range(1, 12)) - 64'd1) << $urandom_range(0, 31);
    return run[31:0];
  endfunction

  // Drive one input beat from a falling edge, hold until accepted, log its prediction.
  // Leave tvalid high on return so back-to-back beats need a single assignment per edge.
  task automatic send_item(input palette_item_t item, input bit typed,
                           input palette_result_t want);
    palette_result_t got;
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= item.op;
    // fields from bit 0: red, green, blue, entry_index, primary_select, zero fill
    in_tdata  <= {6'd0, item.sel, item.idx, item.blue, item.green, item.red};
    do @(posedge clk); while (!in_tready);
    got = palette_result_of(item);
    awaited_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // Drop tvalid, wait until every awaited result has come back, then idle a little longer.
  task automatic settle_palette(input int extra_cycles);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (extra_cycles) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the mask lands at the edge with pready high.
  task automatic write_mask(input logic [1:0] reg_id, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_id, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    pred_mask[reg_id] = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed traffic: fresh adds to fill the table, repeats of this phase's
  // colors to force merges, and reads aimed mainly inside the filled range.
  task automatic run_random_phase(input int n_items);
    logic [23:0]     phase_colors [$];
    palette_item_t   item;
    palette_result_t no_want;
    int              pick;
    for (int n = 0; n < n_items; n++) begin
      pick       = $urandom_range(0, 99);
      item.op    = OP_ADD;
      item.red   = 8'($urandom);
      item.green = 8'($urandom);
      item.blue  = 8'($urandom);
      item.idx   = 8'($urandom);
      item.sel   = 2'($urandom);
      if (pick < 15 && phase_colors.size() > 0) begin
        {item.red, item.green, item.blue} =
          phase_colors[$urandom_range(0, phase_colors.size() - 1)];
      end else if (pick >= 55) begin
        item.op = OP_READ;
        // keep a tenth of the reads on a raw index to reach past the count
        if ($urandom_range(0, 9) != 0 && pred_count != 0)
          item.idx = 8'($urandom_range(0, int'(pred_count) - 1));
      end
      if (item.op == OP_ADD) phase_colors.push_back({item.red, item.green, item.blue});
      send_item(item, 1'b0, no_want);
    end
  endtask

  // Receiver: stall about a quarter of the cycles, never during the steady stretch.
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 24);
  end

  // Compare each result beat against the oldest prediction, field by field.
  always @(posedge clk) begin : check_results
    palette_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        // tdata from bit 0: pixel_value, result_index, selected_level, entry_count
        if (out_tdata[31:0] !== want.pixel) begin
          $error("pixel_value: expected %08h, got %08h", want.pixel, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[39:32] !== want.index) begin
          $error("result_index: expected %0d, got %0d", want.index, out_tdata[39:32]);
          mismatch_count++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[47:40] !== want.level) begin
          $error("selected_level: expected %0d, got %0d", want.level, out_tdata[47:40]);
          mismatch_count++;
        end
        if (out_tdata[56:48] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_tdata[56:48]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t   directed [$];
    logic [31:0] masks [3];

    pred_count                 = 9'd0;
    pred_mask[REG_RED_MASK]    = 32'h00FF0000;
    pred_mask[REG_GREEN_MASK]  = 32'h0000FF00;
    pred_mask[REG_BLUE_MASK]   = 32'h000000FF;

    // Empty table: any read is out of range, including the top index with selector three.
    directed.push_back(checked_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd0, SEL_RED,
                                   32'h0, 8'd0, STAT_READ_OOR, 8'd0, 9'd0));
    directed.push_back(checked_row(OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'd255, SEL_NONE,
                                   32'h0, 8'd255, STAT_READ_OOR, 8'd0, 9'd0));
    // Default masks: extremes, a repeat that merges, and each primary alone.
    directed.push_back(checked_row(OP_ADD, 8'h00, 8'h00, 8'h00, 8'd255, SEL_NONE,
                                   32'h0, 8'd0, STAT_ADDED, 8'd0, 9'd1));
    directed.push_back(checked_row(OP_ADD, 8'hFF, 8'hFF, 8'hFF, 8'd0, SEL_RED,
                                   32'h00FFFFFF, 8'd1, STAT_ADDED, 8'd0, 9'd2));
    directed.push_back(checked_row(OP_ADD, 8'h00, 8'h00, 8'h00, 8'd7, SEL_BLUE,
                                   32'h0, 8'd0, STAT_MERGED, 8'd0, 9'd2));
    directed.push_back(checked_row(OP_ADD, 8'hFF, 8'h00, 8'h00, 8'd0, SEL_RED,
                                   32'h00FF0000, 8'd2, STAT_ADDED, 8'd0, 9'd3));
    directed.push_back(checked_row(OP_ADD, 8'h00, 8'hFF, 8'h00, 8'd0, SEL_RED,
                                   32'h0000FF00, 8'd3, STAT_ADDED, 8'd0, 9'd4));
    directed.push_back(checked_row(OP_ADD, 8'h00, 8'h00, 8'hFF, 8'd0, SEL_RED,
                                   32'h000000FF, 8'd4, STAT_ADDED, 8'd0, 9'd5));
    // Reads of each primary, selector three, and an index equal to the count.
    directed.push_back(checked_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd1, SEL_RED,
                                   32'h00FFFFFF, 8'd1, STAT_READ_OK, 8'd255, 9'd5));
    directed.push_back(checked_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd2, SEL_GREEN,
                                   32'h00FF0000, 8'd2, STAT_READ_OK, 8'd0, 9'd5));
    directed.push_back(checked_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd4, SEL_BLUE,
                                   32'h000000FF, 8'd4, STAT_READ_OK, 8'd255, 9'd5));
    directed.push_back(checked_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd1, SEL_NONE,
                                   32'h00FFFFFF, 8'd1, STAT_READ_OK, 8'd0, 9'd5));
    directed.push_back(checked_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd5, SEL_RED,
                                   32'h0, 8'd5, STAT_READ_OOR, 8'd0, 9'd5));
    directed.push_back(item_row(OP_ADD, 8'h12, 8'h34, 8'h56, 8'd0, SEL_RED));
    directed.push_back(item_row(OP_ADD, 8'hA5, 8'h5A, 8'hC3, 8'd0, SEL_RED));
    directed.push_back(item_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd5, SEL_GREEN));
    directed.push_back(item_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd6, SEL_BLUE));
    // Zero red mask, a green run wider than 8 bits, a blue mask with several runs.
    directed.push_back(cfg_row(REG_RED_MASK, 32'h00000000));
    directed.push_back(cfg_row(REG_GREEN_MASK, 32'h0000FFF0));
    directed.push_back(cfg_row(REG_BLUE_MASK, 32'h00000505));
    directed.push_back(item_row(OP_ADD, 8'hFF, 8'h81, 8'h80, 8'd0, SEL_RED));
    directed.push_back(item_row(OP_ADD, 8'h7F, 8'hFF, 8'h7F, 8'd0, SEL_RED));
    directed.push_back(item_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd7, SEL_RED));
    directed.push_back(item_row(OP_ADD, 8'hFF, 8'h81, 8'h80, 8'd0, SEL_RED));
    // All-ones masks: every primary lands on the same low byte.
    directed.push_back(cfg_row(REG_RED_MASK, 32'hFFFFFFFF));
    directed.push_back(cfg_row(REG_GREEN_MASK, 32'hFFFFFFFF));
    directed.push_back(cfg_row(REG_BLUE_MASK, 32'hFFFFFFFF));
    directed.push_back(item_row(OP_ADD, 8'h5A, 8'h0F, 8'hF0, 8'd0, SEL_RED));
    directed.push_back(item_row(OP_READ, 8'h00, 8'h00, 8'h00, 8'd8, SEL_NONE));

    // Hold reset low, then release it on a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle_palette(4);
        write_mask(directed[i].reg_id, directed[i].reg_value);
      end else begin
        send_item(directed[i].item, directed[i].typed, directed[i].want);
      end
    end

    // Early phases fill the table; later ones run against a full table and see drops.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       masks = '{32'h00FF0000, 32'h0000FF00, 32'h000000FF};
        1:       masks = '{32'h0000F800, 32'h000007E0, 32'h0000001F};
        2:       masks = '{32'hFFFFFFFF, 32'h00000000, 32'h80000000};
        3:       masks = '{random_run_mask(), random_run_mask(), random_run_mask()};
        4:       masks = '{32'h00000003, 32'h0000000C, 32'h00000030};
        5:       masks = '{$urandom, $urandom, $urandom};
        6:       masks = '{32'hFF000000, 32'h00FF0000, 32'h0000FF00};
        default: masks = '{32'h00FF0000, 32'h0000FF00, 32'h000000FF};
      endcase
      settle_palette(4);
      write_mask(REG_RED_MASK, masks[0]);
      write_mask(REG_GREEN_MASK, masks[1]);
      write_mask(REG_BLUE_MASK, masks[2]);
      steady = (p == 2);
      run_random_phase(PHASE_ITEMS);
    end
    steady = 1'b0;

    settle_palette(TAIL_CYCLES);
    if (mismatch_count == 0) begin
      $display("palette_pixel_dedup_table_unit_test: PASS");
    end else begin
      $display("palette_pixel_dedup_table_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #50_000_000;
    $display("palette_pixel_dedup_table_unit_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ppdt_pkg.sv
rtl/core/ppdt_ram.sv
rtl/core/ppdt_ctrl.sv
rtl/core/ppdt_dp.sv
rtl/core/palette_pixel_dedup_table_unit.sv
bench/palette_pixel_dedup_table_unit_test.sv
